// ===== src/mmpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// Mecanum mixer PWM package
// Shared widths, register indexes, reset values and transfer types for the
// mecanum wheel mixer with PWM compare outputs.
// ----------------------------------------------------------------------------
package mmpwm_pkg;

    // Default number of fraction bits in the fixed-point speed formats.
    localparam int FRAC_BITS_DEF = 13;

    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int NUM_WHEELS = 4;

    // Configuration port and register widths.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int LIMIT_W    = 15;
    localparam int DGAIN_W    = 15;
    localparam int PGAIN_W    = 12;
    localparam int CENTER_W   = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_GAIN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PWM_GAIN       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PWM_CENTER     = CFG_IDX_W'(3);

    // Register reset values.
    localparam logic [LIMIT_W-1:0]  SPEED_LIMIT_RST    = LIMIT_W'(4096);
    localparam logic [DGAIN_W-1:0]  DIRECTION_GAIN_RST = DGAIN_W'(9011);
    localparam logic [PGAIN_W-1:0]  PWM_GAIN_RST       = PGAIN_W'(210);
    localparam logic [CENTER_W-1:0] PWM_CENTER_RST     = CENTER_W'(1500);

    // One motion command.
    typedef struct packed {
        logic signed [IN_W-1:0] speed_x;
        logic signed [IN_W-1:0] speed_y;
        logic signed [IN_W-1:0] spin_rate;
        logic signed [IN_W-1:0] speed_trim;
        logic                   link_ok;
    } cmd_t;

    // One set of compare values.
    typedef struct packed {
        logic [OUT_W-1:0] cmp_tim2_ch1;
        logic [OUT_W-1:0] cmp_tim2_ch2;
        logic [OUT_W-1:0] cmp_tim8_ch3;
        logic [OUT_W-1:0] cmp_tim8_ch4;
    } pwm_t;

    // Clamped speed of one wheel and whether the direction gain applies.
    typedef struct packed {
        logic signed [IN_W-1:0] speed;
        logic                   gain_sel;
    } wheel_t;

    // Hand-over between the mixing and the compare halves of the pipeline.
    typedef struct packed {
        wheel_t [NUM_WHEELS-1:0] wheel;
        logic                    link_ok;
    } wheel_set_t;

endpackage

// ===== src/mecanum_mixer_pwm_core.sv =====
// ----------------------------------------------------------------------------
// Mecanum mixer with PWM compare outputs
// Mixes one motion command into four wheel compare values per transfer.
// ----------------------------------------------------------------------------
// Usage. A motion command (sideways, forward, spin and trim speeds plus the
// link flag) is offered on the cmd channel and is taken on a transfer, when
// cmd_valid and cmd_ready are both high. Exactly one set of four compare
// values leaves on the pwm channel for every command, in the same order.
// The pipeline has seven register stages: the coefficient multipliers, the
// wheel sums, the scale and clamp stage, the direction gain multiplier, the
// PWM gain multiplier, the centre subtraction and the final truncation and
// saturation stage. With the receiver ready, a command transfers every cycle
// and passes through each of these stages in turn. When the receiver stalls,
// each stage holds its item and bubbles further up are squeezed out, so new
// commands are still taken until the pipeline is full. The four configuration
// registers are written over the cfg channel, which is always ready; they are
// meant to change only while the pipeline is empty. Reset empties the pipeline
// and loads the register defaults: speed limit 0.5, direction gain 1.1, PWM
// gain 210, centre 1500.
// ----------------------------------------------------------------------------
module mecanum_mixer_pwm_core #(
    parameter int FRAC_BITS = mmpwm_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  mmpwm_pkg::cmd_t                  cmd,
    output logic                             pwm_valid,
    input  logic                             pwm_ready,
    output mmpwm_pkg::pwm_t                  pwm,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mmpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mmpwm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mmpwm_pkg::*;

    // Configuration registers.
    logic [LIMIT_W-1:0]  speed_limit_reg;
    logic [DGAIN_W-1:0]  direction_gain_reg;
    logic [PGAIN_W-1:0]  pwm_gain_reg;
    logic [CENTER_W-1:0] pwm_center_reg;

    // Transfer channel between the mixing half and the compare half.
    logic       mid_valid;
    logic       mid_ready;
    wheel_set_t mid_set;

    // Register writes are taken at once; the port never back-pressures.
    assign cfg_ready = 1'b1;

    // Writes to indexes beyond the register list are dropped, and data bits
    // above a register's width are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg    <= SPEED_LIMIT_RST;
            direction_gain_reg <= DIRECTION_GAIN_RST;
            pwm_gain_reg       <= PWM_GAIN_RST;
            pwm_center_reg     <= PWM_CENTER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SPEED_LIMIT:    speed_limit_reg    <= cfg_data[LIMIT_W-1:0];
                REG_DIRECTION_GAIN: direction_gain_reg <= cfg_data[DGAIN_W-1:0];
                REG_PWM_GAIN:       pwm_gain_reg       <= cfg_data[PGAIN_W-1:0];
                REG_PWM_CENTER:     pwm_center_reg     <= cfg_data[CENTER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Products, wheel sums, scaling and clamping.
    mmpwm_mix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mix (
        .clk         (clk),
        .rst_n       (rst_n),
        .speed_limit (speed_limit_reg),
        .in_valid    (cmd_valid),
        .in_ready    (cmd_ready),
        .in_cmd      (cmd),
        .out_valid   (mid_valid),
        .out_ready   (mid_ready),
        .out_set     (mid_set)
    );

    // Gains, centre subtraction, saturation and the link-lost override.
    mmpwm_cmp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cmp (
        .clk            (clk),
        .rst_n          (rst_n),
        .direction_gain (direction_gain_reg),
        .pwm_gain       (pwm_gain_reg),
        .pwm_center     (pwm_center_reg),
        .in_valid       (mid_valid),
        .in_ready       (mid_ready),
        .in_set         (mid_set),
        .out_valid      (pwm_valid),
        .out_ready      (pwm_ready),
        .out_pwm        (pwm)
    );

endmodule

// ===== src/mmpwm_mix.sv =====
// ----------------------------------------------------------------------------
// Mecanum mixer: mixing stages
// Three register stages: coefficient products, wheel sums, then scaling,
// clamping to the speed limit and selection of the direction gain.
// ----------------------------------------------------------------------------
module mmpwm_mix #(
    parameter int FRAC_BITS = mmpwm_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mmpwm_pkg::LIMIT_W-1:0] speed_limit,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  mmpwm_pkg::cmd_t               in_cmd,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mmpwm_pkg::wheel_set_t         out_set
);
    import mmpwm_pkg::*;

    localparam int     CW  = FRAC_BITS + 2;
    localparam longint K09 = ((longint'(9) << FRAC_BITS) + 5) / 10;
    localparam longint K18 = ((longint'(18) << FRAC_BITS) + 5) / 10;
    localparam logic signed [CW-1:0] K09_C = CW'(K09);
    localparam logic signed [CW-1:0] K18_C = CW'(K18);
    localparam int PW = IN_W + CW;
    localparam int SW = PW + 2;
    localparam int QW = SW - FRAC_BITS;
    localparam logic signed [SW-1:0] BIAS = SW'((longint'(1) << FRAC_BITS) - 1);
    // Wheels one and two take the direction gain on negative speeds.
    localparam logic [NUM_WHEELS-1:0] GAIN_ON_NEG = NUM_WHEELS'(4'b0110);

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic signed [PW-1:0] px_reg, py_reg, ps_reg, pt_reg;
    logic signed [PW-1:0] px_next, py_next, ps_next, pt_next;
    logic                 link1_reg, link2_reg;

    logic signed [SW-1:0] sum_reg  [NUM_WHEELS];
    logic signed [SW-1:0] sum_next [NUM_WHEELS];
    logic signed [SW-1:0] xe, ye, se, te;

    logic signed [SW-1:0] biased [NUM_WHEELS];
    logic signed [QW-1:0] scaled [NUM_WHEELS];
    logic signed [QW-1:0] clamped [NUM_WHEELS];
    logic signed [QW-1:0] lim_pos, lim_neg;

    wheel_set_t set_reg, set_next;

    // Each stage moves on when it is empty or the next one moves on.
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign out_valid = v3_reg;
    assign out_set   = set_reg;

    always_comb
    begin
        px_next = PW'(in_cmd.speed_x) * PW'(K09_C);
        py_next = PW'(in_cmd.speed_y) * PW'(K09_C);
        ps_next = PW'(in_cmd.spin_rate) * PW'(K18_C);
        pt_next = PW'(in_cmd.speed_trim) * PW'(K09_C);
    end

    always_comb
    begin
        xe = SW'(px_reg);
        ye = SW'(py_reg);
        se = SW'(ps_reg);
        te = SW'(pt_reg);
        sum_next[0] =  xe + ye + se + te;
        sum_next[1] = -xe + ye - se + te;
        sum_next[2] =  xe + ye - se - te;
        sum_next[3] = -xe + ye + se - te;
    end

    // Truncate toward zero by adding a bias to negative sums before shifting.
    always_comb
    begin
        lim_pos = $signed({{(QW - LIMIT_W){1'b0}}, speed_limit});
        lim_neg = -lim_pos;
        set_next.link_ok = link2_reg;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            biased[i] = sum_reg[i] + (sum_reg[i][SW-1] ? BIAS : '0);
            scaled[i] = QW'(biased[i] >>> FRAC_BITS);
            if (scaled[i] > lim_pos)
            begin
                clamped[i] = lim_pos;
            end
            else if (scaled[i] < lim_neg)
            begin
                clamped[i] = lim_neg;
            end
            else
            begin
                clamped[i] = scaled[i];
            end
            set_next.wheel[i].speed = clamped[i][IN_W-1:0];
            if (GAIN_ON_NEG[i])
            begin
                set_next.wheel[i].gain_sel = clamped[i] < 0;
            end
            else
            begin
                set_next.wheel[i].gain_sel = clamped[i] > 0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            ps_reg    <= ps_next;
            pt_reg    <= pt_next;
            link1_reg <= in_cmd.link_ok;
        end
        if (en2)
        begin
            sum_reg   <= sum_next;
            link2_reg <= link1_reg;
        end
        if (en3)
        begin
            set_reg <= set_next;
        end
    end

endmodule

// ===== src/mmpwm_cmp.sv =====
// ----------------------------------------------------------------------------
// Mecanum mixer: compare stages
// Four register stages: speed times direction gain, times PWM gain,
// subtraction from the centre value, then truncation and saturation.
// ----------------------------------------------------------------------------
module mmpwm_cmp #(
    parameter int FRAC_BITS = mmpwm_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [mmpwm_pkg::DGAIN_W-1:0]  direction_gain,
    input  logic [mmpwm_pkg::PGAIN_W-1:0]  pwm_gain,
    input  logic [mmpwm_pkg::CENTER_W-1:0] pwm_center,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  mmpwm_pkg::wheel_set_t          in_set,
    output logic                           out_valid,
    input  logic                           out_ready,
    output mmpwm_pkg::pwm_t                out_pwm
);
    import mmpwm_pkg::*;

    localparam int GW  = (FRAC_BITS + 1 > DGAIN_W) ? FRAC_BITS + 1 : DGAIN_W;
    localparam logic [GW-1:0] ONE_G = GW'(longint'(1) << FRAC_BITS);
    localparam int SGW = IN_W + GW + 1;
    localparam int PGW = SGW + PGAIN_W + 1;
    localparam int CSH = 2 * FRAC_BITS;
    localparam int NW  = ((CENTER_W + CSH > PGW) ? CENTER_W + CSH : PGW) + 2;
    localparam int QW  = NW - CSH;
    localparam logic signed [NW-1:0] BIAS = NW'((longint'(1) << CSH) - 1);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    logic link1_reg, link2_reg, link3_reg;

    logic [GW-1:0]         gain [NUM_WHEELS];
    logic signed [SGW-1:0] sg_reg  [NUM_WHEELS];
    logic signed [SGW-1:0] sg_next [NUM_WHEELS];
    logic signed [PGW-1:0] pg_reg  [NUM_WHEELS];
    logic signed [PGW-1:0] pg_next [NUM_WHEELS];
    logic signed [NW-1:0]  num_reg  [NUM_WHEELS];
    logic signed [NW-1:0]  num_next [NUM_WHEELS];
    logic signed [NW-1:0]  center_sh;
    logic signed [NW-1:0]  biased [NUM_WHEELS];
    logic signed [QW-1:0]  quot [NUM_WHEELS];
    logic [OUT_W-1:0]      sat [NUM_WHEELS];

    pwm_t pwm_reg, pwm_next;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign out_valid = v4_reg;
    assign out_pwm   = pwm_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            gain[i]    = in_set.wheel[i].gain_sel ? GW'(direction_gain) : ONE_G;
            sg_next[i] = SGW'(in_set.wheel[i].speed) * SGW'($signed({1'b0, gain[i]}));
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            pg_next[i] = PGW'(sg_reg[i]) * PGW'($signed({1'b0, pwm_gain}));
        end
    end

    always_comb
    begin
        center_sh = NW'($signed({1'b0, pwm_center})) <<< CSH;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            num_next[i] = center_sh - NW'(pg_reg[i]);
        end
    end

    // Truncate toward zero, then saturate to the compare range; a lost link sends the centre value.
    always_comb
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            biased[i] = num_reg[i] + (num_reg[i][NW-1] ? BIAS : '0);
            quot[i]   = QW'(biased[i] >>> CSH);
            if (quot[i][QW-1])
            begin
                sat[i] = '0;
            end
            else if (|quot[i][QW-2:OUT_W])
            begin
                sat[i] = '1;
            end
            else
            begin
                sat[i] = quot[i][OUT_W-1:0];
            end
            if (!link3_reg)
            begin
                sat[i] = pwm_center;
            end
        end
        pwm_next.cmp_tim2_ch1 = sat[3];
        pwm_next.cmp_tim2_ch2 = sat[2];
        pwm_next.cmp_tim8_ch3 = sat[0];
        pwm_next.cmp_tim8_ch4 = sat[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sg_reg    <= sg_next;
            link1_reg <= in_set.link_ok;
        end
        if (en2)
        begin
            pg_reg    <= pg_next;
            link2_reg <= link1_reg;
        end
        if (en3)
        begin
            num_reg   <= num_next;
            link3_reg <= link2_reg;
        end
        if (en4)
        begin
            pwm_reg <= pwm_next;
        end
    end

endmodule

// ===== src/mmpwm_chk.sv =====
// ----------------------------------------------------------------------------
// Mecanum mixer port checker
// Watches the ports of the mixer core for handshake, flow and latency slips.
// ----------------------------------------------------------------------------
module mmpwm_chk (
    input logic            clk,
    input logic            rst_n,
    input logic            cmd_valid,
    input logic            cmd_ready,
    input logic            pwm_valid,
    input logic            pwm_ready,
    input mmpwm_pkg::pwm_t pwm,
    input logic            cfg_valid,
    input logic            cfg_ready
);
    import mmpwm_pkg::*;

    // A stalled result stays on the port unchanged.
    a_pwm_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pwm_valid && !pwm_ready |=> pwm_valid && $stable(pwm))
        else $error("stalled result changed or vanished");

    // With room at the output the whole pipeline moves, so commands are taken.
    a_cmd_room: assert property (@(posedge clk) disable iff (!rst_n)
        (!pwm_valid || pwm_ready) |-> cmd_ready)
        else $error("command refused while the output had room");

    // Register writes never wait.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write held off");

    // A command that meets no stall reaches the output after seven stages.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) ##1 pwm_ready ##1 pwm_ready ##1 pwm_ready
        ##1 pwm_ready ##1 pwm_ready ##1 pwm_ready |=> pwm_valid)
        else $error("result missing after the pipeline latency");

endmodule

bind mecanum_mixer_pwm_core mmpwm_chk u_chk (.*);
